### design/matrix_inverse_3x3_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse core
// Shared helpers that wrap implication and next-cycle properties.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_CORE_MACROS_SVH
`define MATRIX_INVERSE_3X3_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MI3_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mi3x3 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MI3_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mi3x3 check failed");

`endif

### design/mi3x3_pkg.sv
// ----------------------------------------------------------------------------
// mi3x3_pkg
// Widths, constants and index tables for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package mi3x3_pkg;

    localparam int unsigned N_ELEM    = 9;
    localparam int unsigned ELEM_W    = 32;
    localparam int unsigned TDATA_W   = N_ELEM * ELEM_W;
    localparam int unsigned TUSER_W   = 2;
    localparam int unsigned ADJ_W     = 64;
    localparam int unsigned TERM_W    = 98;
    localparam int unsigned MAG_W     = 97;
    localparam int unsigned REM_W     = 98;
    localparam int unsigned THR_W     = 48;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned PRE_STAGES = 8;
    localparam int unsigned PIPE_DEPTH = PRE_STAGES + DIV_STEPS;

    // Bit positions inside the result tuser.
    localparam int unsigned TUSER_SINGULAR = 0;
    localparam int unsigned TUSER_OVERFLOW = 1;

    localparam logic [THR_W-1:0]  THR_RESET = 48'd2814749767;
    localparam logic [ELEM_W-1:0] LIM_POS   = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] LIM_NEG   = 32'h8000_0000;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [ADJ_W-1:0]  adj_t;
    typedef logic [3:0]               idx_t;

    // Cofactor k = m[a]*m[b] - m[c]*m[d], stored as {a, b, c, d}.
    localparam idx_t ADJ_IDX [N_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Cofactor that multiplies element j of the first row in the determinant.
    localparam idx_t DET_COF [3] = '{4'd0, 4'd3, 4'd6};

endpackage

### design/matrix_inverse_3x3_core.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core
// Pipelined 3x3 matrix inverse by adjugate and restoring division.
// ----------------------------------------------------------------------------
// Usage:
// One matrix enters per transfer on the s_ channel: nine signed Q16.16
// elements in storage order. One result leaves per transfer on the m_
// channel: nine signed Q16.16 inverse elements plus singular and overflow
// flags in m_tuser. The cfg channel writes the 48-bit singular threshold
// (units of 2^-48); it is always ready and should be written while idle.
// Throughput is one matrix per cycle while no result is held back: 8
// stages register the input and form products, cofactors, determinant,
// magnitudes and division setup, then 32 stages do one quotient bit each
// in nine parallel division lanes, and a last register saturates and signs.
// The whole pipeline advances on one enable; when the receiver holds
// m_tready low with a result waiting, all stages and s_tready hold, so
// nothing is lost or repeated. Reset empties the pipeline and loads the
// default threshold (about 1.0e-5).
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: m0, m1, ..., m8 (32 bits each).
    input  logic [mi3x3_pkg::TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: r0, r1, ..., r8 (32 bits each).
    output logic [mi3x3_pkg::TDATA_W-1:0] m_tdata,
    // Fields from bit 0 up: singular, overflow.
    output logic [mi3x3_pkg::TUSER_W-1:0] m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mi3x3_pkg::THR_W-1:0]   cfg_data
);

    localparam int unsigned NE = mi3x3_pkg::N_ELEM;
    localparam int unsigned DS = mi3x3_pkg::DIV_STEPS;

    logic                              pipe_en;
    logic [mi3x3_pkg::THR_W-1:0]       thr_reg;
    logic [mi3x3_pkg::PIPE_DEPTH-1:0]  vld_reg;
    logic                              out_vld_reg;

    mi3x3_pkg::elem_t                  m_reg     [NE];
    logic signed [63:0]                ppos_reg  [NE];
    logic signed [63:0]                pneg_reg  [NE];
    mi3x3_pkg::elem_t                  row1_reg  [3];
    mi3x3_pkg::adj_t                   adj2_reg  [NE];
    mi3x3_pkg::elem_t                  row2_reg  [3];
    logic signed [64:0]                tlo_reg   [3];
    logic signed [63:0]                thi_reg   [3];
    mi3x3_pkg::adj_t                   adj3_reg  [NE];
    logic signed [mi3x3_pkg::TERM_W-1:0] term_reg [3];
    mi3x3_pkg::adj_t                   adj4_reg  [NE];
    logic signed [mi3x3_pkg::TERM_W-1:0] det_reg;
    mi3x3_pkg::adj_t                   adj5_reg  [NE];
    logic [mi3x3_pkg::MAG_W-1:0]       dmag6_reg;
    logic                              dneg6_reg;
    logic                              sing6_reg;
    logic [63:0]                       am6_reg   [NE];
    logic                              aneg6_reg [NE];

    // Division lanes: index 0 is loaded from stage 6, index DS is the last step.
    logic [mi3x3_pkg::REM_W-1:0]       rem_reg   [DS+1][NE];
    logic [mi3x3_pkg::ELEM_W-1:0]      quo_reg   [DS+1][NE];
    logic                              big_reg   [DS+1][NE];
    logic                              neg_reg   [DS+1][NE];
    logic [mi3x3_pkg::MAG_W-1:0]       dmag_reg  [DS+1];
    logic                              sing_reg  [DS+1];

    logic [mi3x3_pkg::REM_W-1:0]       rem_next  [DS][NE];
    logic                              qbit_next [DS][NE];

    logic [mi3x3_pkg::ELEM_W-1:0]      r_reg     [NE];
    logic                              sing_out_reg;
    logic                              ovf_out_reg;

    // One enable for every stage: move whenever the output slot is free or being taken.
    assign pipe_en   = !out_vld_reg || m_tready;
    assign s_tready  = pipe_en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= mi3x3_pkg::THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            vld_reg     <= {vld_reg[mi3x3_pkg::PIPE_DEPTH-2:0], s_tvalid};
            out_vld_reg <= vld_reg[mi3x3_pkg::PIPE_DEPTH-1];
        end
    end

    // One restoring division step per lane and stage.
    always_comb begin
        logic [mi3x3_pkg::REM_W-1:0] shifted;
        logic [mi3x3_pkg::REM_W-1:0] dext;
        for (int i = 0; i < DS; i++) begin
            for (int k = 0; k < NE; k++) begin
                shifted = {rem_reg[i][k][mi3x3_pkg::REM_W-2:0], 1'b0};
                dext    = {1'b0, dmag_reg[i]};
                qbit_next[i][k] = (shifted >= dext);
                rem_next[i][k]  = qbit_next[i][k] ? (shifted - dext) : shifted;
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge aclk) begin
        logic [mi3x3_pkg::ELEM_W-1:0] lim;
        logic [mi3x3_pkg::ELEM_W-1:0] val;
        logic                         sat;
        logic                         ovf;
        logic signed [mi3x3_pkg::TERM_W-1:0] dsel;
        if (pipe_en) begin
            // Input register.
            for (int k = 0; k < NE; k++) begin
                m_reg[k] <= s_tdata[k*mi3x3_pkg::ELEM_W +: mi3x3_pkg::ELEM_W];
            end

            // Element products for the cofactors.
            for (int k = 0; k < NE; k++) begin
                ppos_reg[k] <= m_reg[mi3x3_pkg::ADJ_IDX[k][0]]
                             * m_reg[mi3x3_pkg::ADJ_IDX[k][1]];
                pneg_reg[k] <= m_reg[mi3x3_pkg::ADJ_IDX[k][2]]
                             * m_reg[mi3x3_pkg::ADJ_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++) begin
                row1_reg[j] <= m_reg[j];
            end

            // Cofactors; the difference always fits 64 signed bits.
            for (int k = 0; k < NE; k++) begin
                adj2_reg[k] <= ppos_reg[k] - pneg_reg[k];
            end
            for (int j = 0; j < 3; j++) begin
                row2_reg[j] <= row1_reg[j];
            end

            // Determinant terms as two 32-bit partial products each.
            for (int j = 0; j < 3; j++) begin
                tlo_reg[j] <= row2_reg[j]
                    * $signed({1'b0, adj2_reg[mi3x3_pkg::DET_COF[j]][31:0]});
                thi_reg[j] <= row2_reg[j]
                    * $signed(adj2_reg[mi3x3_pkg::DET_COF[j]][63:32]);
            end
            adj3_reg <= adj2_reg;

            // Join the partial products.
            for (int j = 0; j < 3; j++) begin
                term_reg[j] <= $signed({{2{thi_reg[j][63]}}, thi_reg[j], 32'b0})
                             + $signed({{33{tlo_reg[j][64]}}, tlo_reg[j]});
            end
            adj4_reg <= adj3_reg;

            // Determinant.
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            adj5_reg <= adj4_reg;

            // Magnitudes, signs and the singular test.
            dsel      = det_reg[mi3x3_pkg::TERM_W-1] ? -det_reg : det_reg;
            dneg6_reg <= det_reg[mi3x3_pkg::TERM_W-1];
            dmag6_reg <= dsel[mi3x3_pkg::MAG_W-1:0];
            sing6_reg <= (dsel[mi3x3_pkg::MAG_W-1:0]
                          <= {{(mi3x3_pkg::MAG_W-mi3x3_pkg::THR_W){1'b0}}, thr_reg});
            for (int k = 0; k < NE; k++) begin
                am6_reg[k]   <= adj5_reg[k][63] ? 64'(-adj5_reg[k]) : 64'(adj5_reg[k]);
                aneg6_reg[k] <= adj5_reg[k][63];
            end

            // Division setup: a quotient of 2^32 or more is flagged up front.
            dmag_reg[0] <= dmag6_reg;
            sing_reg[0] <= sing6_reg;
            for (int k = 0; k < NE; k++) begin
                rem_reg[0][k] <= {34'b0, am6_reg[k]};
                quo_reg[0][k] <= '0;
                big_reg[0][k] <= ({33'b0, am6_reg[k]} >= dmag6_reg);
                neg_reg[0][k] <= aneg6_reg[k] ^ dneg6_reg;
            end

            // Quotient bit stages.
            for (int i = 0; i < DS; i++) begin
                dmag_reg[i+1] <= dmag_reg[i];
                sing_reg[i+1] <= sing_reg[i];
                for (int k = 0; k < NE; k++) begin
                    rem_reg[i+1][k] <= rem_next[i][k];
                    quo_reg[i+1][k] <= {quo_reg[i][k][mi3x3_pkg::ELEM_W-2:0],
                                        qbit_next[i][k]};
                    big_reg[i+1][k] <= big_reg[i][k];
                    neg_reg[i+1][k] <= neg_reg[i][k];
                end
            end

            // Saturation, sign and the singular override.
            ovf = 1'b0;
            for (int k = 0; k < NE; k++) begin
                lim = neg_reg[DS][k] ? mi3x3_pkg::LIM_NEG : mi3x3_pkg::LIM_POS;
                sat = big_reg[DS][k] || (quo_reg[DS][k] > lim);
                val = sat ? lim : quo_reg[DS][k];
                ovf = ovf | sat;
                if (sing_reg[DS]) begin
                    r_reg[k] <= '0;
                end else begin
                    r_reg[k] <= neg_reg[DS][k] ? -val : val;
                end
            end
            sing_out_reg <= sing_reg[DS];
            ovf_out_reg  <= ovf && !sing_reg[DS];
        end
    end

    // Output packing.
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            m_tdata[k*mi3x3_pkg::ELEM_W +: mi3x3_pkg::ELEM_W] = r_reg[k];
        end
        m_tuser[mi3x3_pkg::TUSER_SINGULAR] = sing_out_reg;
        m_tuser[mi3x3_pkg::TUSER_OVERFLOW] = ovf_out_reg;
    end

endmodule

### design/mi3x3_checker.sv
// ----------------------------------------------------------------------------
// mi3x3_checker
// Port-level checks for the 3x3 matrix inverse core, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_core_macros.svh"

module mi3x3_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mi3x3_pkg::TDATA_W-1:0] m_tdata,
    input logic [mi3x3_pkg::TUSER_W-1:0] m_tuser
);

    logic sing_flag;
    logic ovf_flag;

    assign sing_flag = m_tuser[mi3x3_pkg::TUSER_SINGULAR];
    assign ovf_flag  = m_tuser[mi3x3_pkg::TUSER_OVERFLOW];

    // A singular result is the zero matrix without overflow.
    `MI3_ASSERT_IMP(a_sing_zero, aclk, aresetn, m_tvalid && sing_flag, m_tdata == '0)
    `MI3_ASSERT_IMP(a_sing_no_ovf, aclk, aresetn, m_tvalid && sing_flag, !ovf_flag)

    // With the output slot empty the block must take input.
    `MI3_ASSERT_IMP(a_ready_free, aclk, aresetn, !m_tvalid, s_tready)

    // A result that is not taken holds.
    `MI3_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind matrix_inverse_3x3_core mi3x3_checker u_mi3x3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/matrix_inverse_3x3_core_tb.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core_tb
// Drives 3x3 matrices with random gaps and back-pressure, predicts each
// inverse with a bit-exact adjugate and long-division model, and checks
// every result transfer in order over several threshold settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module matrix_inverse_3x3_core_tb;

    typedef struct packed {
        logic [mi3x3_pkg::TDATA_W-1:0] data;
        logic [mi3x3_pkg::TUSER_W-1:0] user;
    } inverse_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = mi3x3_pkg::PIPE_DEPTH + 10;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mi3x3_pkg::TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mi3x3_pkg::TDATA_W-1:0] m_tdata;
    logic [mi3x3_pkg::TUSER_W-1:0] m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [mi3x3_pkg::THR_W-1:0]   cfg_data = '0;

    logic [mi3x3_pkg::TDATA_W-1:0] matrix_q[$];
    inverse_t                      inverse_q[$];
    logic [mi3x3_pkg::THR_W-1:0]   threshold = mi3x3_pkg::THR_RESET;
    int                            mismatch_count = 0;
    int                            idle_cycles = 0;
    int                            send_gap = 0;
    int                            recv_gap = 0;

    matrix_inverse_3x3_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Exact inverse of one matrix under the current threshold.
    function automatic inverse_t compute_inverse(logic [mi3x3_pkg::TDATA_W-1:0] mat);
        logic signed [63:0]  m [9];
        logic signed [63:0]  adj [9];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [127:0]        num;
        logic [127:0]        quo;
        logic [63:0]         am;
        logic [31:0]         limit;
        logic [31:0]         v;
        logic                neg;
        inverse_t            res;
        res = '0;
        for (int k = 0; k < 9; k++) m[k] = $signed(mat[k*32 +: 32]);
        adj[0] = m[4]*m[8] - m[5]*m[7];
        adj[1] = m[2]*m[7] - m[1]*m[8];
        adj[2] = m[1]*m[5] - m[2]*m[4];
        adj[3] = m[5]*m[6] - m[3]*m[8];
        adj[4] = m[0]*m[8] - m[2]*m[6];
        adj[5] = m[2]*m[3] - m[0]*m[5];
        adj[6] = m[3]*m[7] - m[4]*m[6];
        adj[7] = m[1]*m[6] - m[0]*m[7];
        adj[8] = m[0]*m[4] - m[1]*m[3];
        det = 128'(m[0])*128'(adj[0]) + 128'(m[1])*128'(adj[3])
            + 128'(m[2])*128'(adj[6]);
        dmag = det[127] ? -det : det;
        if (dmag <= {80'd0, threshold}) begin
            res.user[mi3x3_pkg::TUSER_SINGULAR] = 1'b1;
            return res;
        end
        for (int k = 0; k < 9; k++) begin
            am = adj[k][63] ? -adj[k] : adj[k];
            neg = adj[k][63] != det[127];
            limit = neg ? mi3x3_pkg::LIM_NEG : mi3x3_pkg::LIM_POS;
            num = {32'd0, am, 32'd0};
            quo = num / dmag;
            if (quo > {96'd0, limit}) begin
                v = limit;
                res.user[mi3x3_pkg::TUSER_OVERFLOW] = 1'b1;
            end else begin
                v = quo[31:0];
            end
            res.data[k*32 +: 32] = neg ? -v : v;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_elem(int mode);
        int r;
        r = $urandom_range(0, 9);
        if (mode == 0 || r < 2) return $urandom;
        if (r < 4) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        // Modest values around one keep determinants in the normal range.
        return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    // Driver: feeds queued matrices with random gaps.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                inverse_q.push_back(compute_inverse(s_tdata));
                send_gap = pick_gap();
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0 || matrix_q.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= matrix_q.pop_front();
                end
            end
        end
    end

    // Monitor: checks each result transfer and drives random back-pressure.
    always @(posedge aclk) begin
        inverse_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (inverse_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
                end else begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (m_tdata[k*32 +: 32] !== want.data[k*32 +: 32])
                            report_mismatch($sformatf("r%0d", k),
                                m_tdata[k*32 +: 32], want.data[k*32 +: 32]);
                    if (m_tuser[mi3x3_pkg::TUSER_SINGULAR]
                        !== want.user[mi3x3_pkg::TUSER_SINGULAR])
                        report_mismatch("singular",
                            32'(m_tuser[mi3x3_pkg::TUSER_SINGULAR]),
                            32'(want.user[mi3x3_pkg::TUSER_SINGULAR]));
                    if (m_tuser[mi3x3_pkg::TUSER_OVERFLOW]
                        !== want.user[mi3x3_pkg::TUSER_OVERFLOW])
                        report_mismatch("overflow",
                            32'(m_tuser[mi3x3_pkg::TUSER_OVERFLOW]),
                            32'(want.user[mi3x3_pkg::TUSER_OVERFLOW]));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                recv_gap = pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer while work is pending.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (inverse_q.size() == 0 && matrix_q.size() == 0 && !s_tvalid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_idle();
        while (matrix_q.size() != 0 || s_tvalid || inverse_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [mi3x3_pkg::THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        threshold = value;
    endtask

    task automatic push_matrix(logic [31:0] e0, logic [31:0] e1, logic [31:0] e2,
                               logic [31:0] e3, logic [31:0] e4, logic [31:0] e5,
                               logic [31:0] e6, logic [31:0] e7, logic [31:0] e8);
        matrix_q.push_back({e8, e7, e6, e5, e4, e3, e2, e1, e0});
    endtask

    task automatic push_random(int count, int mode);
        logic [mi3x3_pkg::TDATA_W-1:0] mat;
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < 9; k++) mat[k*32 +: 32] = rand_elem(mode);
            // Some matrices get a repeated row to force a zero determinant.
            if (mode != 0 && $urandom_range(0, 9) == 0) mat[191:96] = mat[95:0];
            matrix_q.push_back(mat);
        end
    endtask

    initial begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: identity, scaled, singular, tiny determinant, saturation, extremes.
        push_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        push_matrix(32'h0002_0000, 0, 0, 0, 32'hFFFE_0000, 0, 0, 0, 32'h0000_8000);
        push_matrix(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
        push_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_matrix(32'h10, 0, 0, 0, 32'h10, 0, 0, 0, 32'h10);
        push_matrix(32'h100, 0, 0, 0, ONE, 0, 0, 0, ONE);
        push_matrix(32'h1, 0, 0, 0, ONE, 0, 0, 0, 32'hFFFF_FFFF);
        push_matrix(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000);
        push_matrix(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF);
        push_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000);
        push_matrix(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                    32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0001,
                    32'hFFFF_FFFF);
        push_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, ONE);
        wait_idle();

        // Zero threshold: only an exact zero determinant is singular.
        write_threshold('0);
        push_matrix(32'h1, 0, 0, 0, 32'h1, 0, 0, 0, 32'h1);
        push_matrix(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0);
        push_random(300, 1);
        wait_idle();

        // Largest threshold.
        write_threshold('1);
        push_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        push_random(300, 1);
        wait_idle();

        // Random thresholds across the range.
        for (int p = 0; p < 3; p++) begin
            write_threshold(48'({$urandom, $urandom} >> $urandom_range(0, 47)));
            push_random(250, 1);
            push_random(50, 0);
            wait_idle();
        end

        write_threshold(mi3x3_pkg::THR_RESET);
        push_random(300, 1);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/mi3x3_pkg.sv
design/matrix_inverse_3x3_core.sv
design/mi3x3_checker.sv
verif/matrix_inverse_3x3_core_tb.sv
